// ===== src/sccb_pkg.sv =====
// Package of shared types, opcodes and constants for the SCCB register master.
`timescale 1ns / 1ps
package sccb_pkg;

  localparam int unsigned PhaseCountWidth = 16;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } sccb_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       ack_error;
  } sccb_out_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_START = 4'd0,
    OP_WID   = 4'd1,
    OP_WIDR  = 4'd2,
    OP_WREG  = 4'd3,
    OP_WDAT  = 4'd4,
    OP_GAP   = 4'd5,
    OP_STOP  = 4'd6,
    OP_READ  = 4'd7,
    OP_NACK  = 4'd8,
    OP_END   = 4'd9
  } op_e;

  localparam logic [7:0] DevAddrReset    = 8'd66;
  localparam logic [15:0] PhaseTicksReset = 16'd50;
  localparam logic [7:0] ReadBit         = 8'h01;

  localparam logic [1:0] RegDevAddr    = 2'd0;
  localparam logic [1:0] RegPhaseTicks = 2'd1;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] phase_ticks;
  } sccb_cfg_t;

  function automatic op_e prog_op(input logic is_read, input logic [4:0] idx);
    op_e op;
    op = OP_END;
    if (is_read) begin
      case (idx)
        5'd0:  op = OP_START;
        5'd1:  op = OP_WID;
        5'd2:  op = OP_GAP;
        5'd3:  op = OP_WREG;
        5'd4:  op = OP_GAP;
        5'd5:  op = OP_STOP;
        5'd6:  op = OP_GAP;
        5'd7:  op = OP_START;
        5'd8:  op = OP_WIDR;
        5'd9:  op = OP_GAP;
        5'd10: op = OP_READ;
        5'd11: op = OP_NACK;
        5'd12: op = OP_STOP;
        default: op = OP_END;
      endcase
    end else begin
      case (idx)
        5'd0: op = OP_START;
        5'd1: op = OP_WID;
        5'd2: op = OP_GAP;
        5'd3: op = OP_WREG;
        5'd4: op = OP_GAP;
        5'd5: op = OP_WDAT;
        5'd6: op = OP_STOP;
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

  function automatic logic [4:0] op_phases(input op_e op);
    logic [4:0] n;
    unique case (op)
      OP_START: n = 5'd2;
      OP_WID, OP_WIDR, OP_WREG, OP_WDAT: n = 5'd18;
      OP_GAP:  n = 5'd2;
      OP_STOP: n = 5'd3;
      OP_READ: n = 5'd16;
      OP_NACK: n = 5'd4;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== src/sccb_cfg.sv =====
// APB-style configuration register file for the SCCB register master.
`timescale 1ns / 1ps
module sccb_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sccb_pkg::sccb_cfg_t cfg_o
);
  import sccb_pkg::*;

  logic [7:0]  dev_q, dev_d;
  logic [15:0] ticks_q, ticks_d;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_comb begin
    dev_d = dev_q;
    ticks_d = ticks_q;
    if (wr && paddr[1:0] == 2'b00 && paddr[2] == 1'b0) begin
      dev_d = pwdata[7:0];
    end
    if (wr && paddr[1:0] == 2'b00 && paddr[2] == 1'b1) begin
      ticks_d = pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegDevAddr[0]: prdata = {24'd0, dev_q};
      default:       prdata = {16'd0, ticks_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= DevAddrReset;
      ticks_q <= PhaseTicksReset;
    end else begin
      dev_q <= dev_d;
      ticks_q <= ticks_d;
    end
  end

  assign cfg_o.device_address = dev_q;
  assign cfg_o.phase_ticks = ticks_q;
endmodule

// ===== src/sccb_fifo.sv =====
// Two-entry queue that decouples beats between the stages of the master.
`timescale 1ns / 1ps
module sccb_fifo_in (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sccb_pkg::sccb_in_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output sccb_pkg::sccb_in_t data_o,
  output logic              empty_o
);
  import sccb_pkg::*;

  sccb_in_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop = pop_i & ~empty_o;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== src/sccb_out_fifo.sv =====
// Two-entry result queue in front of the result ports.
`timescale 1ns / 1ps
module sccb_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sccb_pkg::sccb_out_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output sccb_pkg::sccb_out_t data_o,
  output logic               empty_o
);
  import sccb_pkg::*;

  sccb_out_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop = pop_i & ~empty_o;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== src/sccb_seq.sv =====
// Bus sequencer that executes one tick per beat and drives the line levels.
`timescale 1ns / 1ps
module sccb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sccb_pkg::sccb_cfg_t  cfg_i,
  input  logic                valid_i,
  input  sccb_pkg::sccb_in_t   tick_i,
  output logic                take_o,
  output logic                valid_o,
  output sccb_pkg::sccb_out_t  res_o,
  input  logic                full_i
);
  import sccb_pkg::*;

  localparam logic [PhaseCountWidth-1:0] Cap = '1;

  logic [4:0] seq_q, seq_d;
  logic [PhaseCountWidth-1:0] pc_q, pc_d;
  logic [3:0] bit_q, bit_d;
  logic half_q, half_d;
  logic [7:0] shift_q, shift_d, rx_q, rx_d, addr_q, addr_d, data_q, data_d;
  logic err_q, err_d, rd_q, rd_d, busy_q, busy_d;
  logic scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic done, busy_out, step, is_byte, first, last;
  logic [4:0] sub, sub_n, seq_n;
  logic [PhaseCountWidth-1:0] lim;
  logic [PhaseCountWidth:0] pc_inc;
  logic [7:0] sb;
  op_e op;

  assign step = valid_i & ~full_i;
  assign take_o = step;
  assign valid_o = step;

  always_comb begin
    seq_d = seq_q; pc_d = pc_q; bit_d = bit_q; half_d = half_q;
    shift_d = shift_q; rx_d = rx_q; addr_d = addr_q; data_d = data_q;
    err_d = err_q; rd_d = rd_q; busy_d = busy_q;
    scl_d = scl_q; sda_d = sda_q; drv_d = drv_q;
    done = 1'b0;
    op = OP_END; sub = 5'd0; sub_n = 5'd0; seq_n = 5'd0;
    first = 1'b0; last = 1'b0; is_byte = 1'b0; sb = 8'd0;
    lim = '0; pc_inc = '0;
    if (cfg_i.phase_ticks == 16'd0) begin
      lim = {{(PhaseCountWidth-1){1'b0}}, 1'b1};
    end else if ({16'd0, cfg_i.phase_ticks} > {{(32-PhaseCountWidth){1'b0}}, Cap}) begin
      lim = Cap;
    end else begin
      lim = PhaseCountWidth'({16'd0, cfg_i.phase_ticks});
    end
    if (!busy_q && (tick_i.command == CMD_WRITE || tick_i.command == CMD_READ)) begin
      busy_d = 1'b1;
      rd_d = tick_i.command == CMD_READ;
      addr_d = tick_i.reg_addr;
      data_d = tick_i.write_data;
      seq_d = 5'd0; pc_d = '0; bit_d = 4'd0; half_d = 1'b0;
      if (tick_i.command == CMD_WRITE) err_d = 1'b0;
    end
    busy_out = busy_d;
    if (busy_d) begin
      op = prog_op(rd_d, seq_d);
      sub = {bit_d, half_d};
      first = pc_d == '0;
      pc_inc = {1'b0, pc_d} + 1'b1;
      last = pc_inc >= {1'b0, lim};
      is_byte = op == OP_WID || op == OP_WIDR || op == OP_WREG || op == OP_WDAT;
      sb = shift_d;
      if (first) begin
        case (op)
          OP_START: begin
            if (sub == 5'd0) begin
              sda_d = 1'b1; scl_d = 1'b1; drv_d = 1'b1;
            end else begin
              sda_d = 1'b0;
            end
          end
          OP_WID, OP_WIDR, OP_WREG, OP_WDAT: begin
            if (sub == 5'd0) begin
              case (op)
                OP_WID:  sb = cfg_i.device_address;
                OP_WIDR: sb = cfg_i.device_address | ReadBit;
                OP_WREG: sb = addr_d;
                default: sb = data_d;
              endcase
              shift_d = sb;
            end
            if (sub < 5'd16) begin
              if (!half_d) begin
                scl_d = 1'b0;
                sda_d = sb[3'd7 - bit_d[2:0]];
              end else begin
                scl_d = 1'b1;
              end
            end else if (sub == 5'd16) begin
              scl_d = 1'b0; drv_d = 1'b0;
            end else begin
              scl_d = 1'b1;
            end
          end
          OP_STOP: begin
            if (sub == 5'd0) sda_d = 1'b0;
            else if (sub == 5'd1) scl_d = 1'b1;
            else sda_d = 1'b1;
          end
          OP_READ: begin
            drv_d = 1'b0;
            scl_d = half_d;
          end
          OP_NACK: begin
            if (sub == 5'd1) begin
              sda_d = 1'b1; scl_d = 1'b1;
            end else if (sub == 5'd2) begin
              scl_d = 1'b0;
            end else if (sub == 5'd3) begin
              sda_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (is_byte && sub == 5'd17 && last && !rd_d && tick_i.sda_in) err_d = 1'b1;
      if (op == OP_READ && half_d && first) rx_d = {rx_q[6:0], tick_i.sda_in};
      pc_d = pc_inc[PhaseCountWidth-1:0];
      if (last) begin
        pc_d = '0;
        sub_n = sub + 5'd1;
        bit_d = sub_n[4:1];
        half_d = sub_n[0];
        if (sub_n >= op_phases(op)) begin
          if (is_byte || op == OP_READ) begin
            scl_d = 1'b0; drv_d = 1'b1;
          end else if (op == OP_START) begin
            scl_d = 1'b0;
          end
          seq_n = seq_d + 5'd1;
          seq_d = seq_n;
          bit_d = 4'd0;
          half_d = 1'b0;
          if (op == OP_END || prog_op(rd_d, seq_n) == OP_END) begin
            busy_d = 1'b0; done = 1'b1; seq_d = 5'd0;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = drv_d & sda_d;
    res_o.sda_drive = drv_d;
    res_o.busy_res = busy_out;
    res_o.done_res = done;
    res_o.read_value = rx_d;
    res_o.ack_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0; pc_q <= '0; bit_q <= '0; half_q <= 1'b0;
      shift_q <= '0; rx_q <= '0; addr_q <= '0; data_q <= '0;
      err_q <= 1'b0; rd_q <= 1'b0; busy_q <= 1'b0;
      scl_q <= 1'b1; sda_q <= 1'b1; drv_q <= 1'b1;
    end else if (step) begin
      seq_q <= seq_d; pc_q <= pc_d; bit_q <= bit_d; half_q <= half_d;
      shift_q <= shift_d; rx_q <= rx_d; addr_q <= addr_d; data_q <= data_d;
      err_q <= err_d; rd_q <= rd_d; busy_q <= busy_d;
      scl_q <= scl_d; sda_q <= sda_d; drv_q <= drv_d;
    end
  end
endmodule

// ===== src/sccb_register_master_top.sv =====
// Top level of the SCCB register master: config port, tick queue, sequencer, result queue.
`timescale 1ns / 1ps
// Each beat on the input is one timing tick of the bus; every tick yields one result
// beat with the line levels and status. A tick enters a two-entry queue, the sequencer
// takes one tick per clock while the result queue has room, and results wait in a
// two-entry queue, so one tick per clock is sustained while pop keeps up. A result beat
// enters the result queue as its tick is taken. The user writes configuration over the APB
// port only while no tick is in flight; the block itself does not enforce it.
module sccb_register_master_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sccb_pkg::sccb_in_t   in_i,
  output logic                empty,
  input  logic                pop,
  output sccb_pkg::sccb_out_t  out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sccb_pkg::*;

  sccb_cfg_t cfg;
  sccb_in_t  tick;
  sccb_out_t res;
  logic q_empty, take, res_valid, res_full;

  sccb_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  sccb_fifo_in u_in_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_i), .full_o(full),
    .pop_i(take), .data_o(tick), .empty_o(q_empty)
  );

  sccb_seq u_seq (
    .clk_i, .rst_ni, .cfg_i(cfg), .valid_i(~q_empty), .tick_i(tick), .take_o(take),
    .valid_o(res_valid), .res_o(res), .full_i(res_full)
  );

  sccb_out_fifo u_out_q (
    .clk_i, .rst_ni, .push_i(res_valid), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_o), .empty_o(empty)
  );
endmodule

// ===== test/tb_sccb_register_master_top.sv =====
// Self-checking testbench for the SCCB register master top level.
`timescale 1ns / 1ps
module tb_sccb_register_master_top;
  import sccb_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SegTicks   = 175;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  sccb_in_t    in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  sccb_out_t   out_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sccb_register_master_top dut (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // bus sequencer mirror
  logic [7:0]  cfg_dev;
  logic [15:0] cfg_phase;
  logic [4:0]  m_step;
  int unsigned m_cnt;
  logic [3:0]  m_bit;
  logic        m_half;
  logic [7:0]  m_shift, m_rx, m_reg, m_data;
  logic        m_err, m_read, m_busy, m_scl, m_sda, m_drv;

  sccb_out_t   line_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;
  bit          hold_req;
  bit          ack_low;

  op_e wr_prog[8] = '{OP_START, OP_WID, OP_GAP, OP_WREG, OP_GAP, OP_WDAT, OP_STOP, OP_END};
  op_e rd_prog[14] = '{OP_START, OP_WID, OP_GAP, OP_WREG, OP_GAP, OP_STOP, OP_GAP,
                       OP_START, OP_WIDR, OP_GAP, OP_READ, OP_NACK, OP_STOP, OP_END};

  function automatic op_e step_op();
    if (m_read) return (m_step < 14) ? rd_prog[m_step] : OP_END;
    return (m_step < 8) ? wr_prog[m_step] : OP_END;
  endfunction

  function automatic int unsigned op_len(input op_e op);
    case (op)
      OP_START, OP_GAP: return 2;
      OP_WID, OP_WIDR, OP_WREG, OP_WDAT: return 18;
      OP_STOP: return 3;
      OP_READ: return 16;
      OP_NACK: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic bit is_byte(input op_e op);
    return op == OP_WID || op == OP_WIDR || op == OP_WREG || op == OP_WDAT;
  endfunction

  function automatic sccb_out_t bus_tick(input sccb_in_t it);
    sccb_out_t   o;
    op_e         op;
    int unsigned sub, lim;
    bit          first, last, done, busy_o;
    done = 0;
    if (!m_busy && (it.command == CMD_WRITE || it.command == CMD_READ)) begin
      m_busy = 1;
      m_read = (it.command == CMD_READ);
      m_reg = it.reg_addr;
      m_data = it.write_data;
      m_step = 0;
      m_cnt = 0;
      m_bit = 0;
      m_half = 0;
      if (!m_read) m_err = 0;
    end
    busy_o = m_busy;
    if (m_busy) begin
      op = step_op();
      sub = m_bit * 2 + m_half;
      lim = (cfg_phase == 0) ? 1 : cfg_phase;
      first = (m_cnt == 0);
      last = (m_cnt + 1 >= lim);
      if (first) begin
        case (op)
          OP_START: begin
            if (sub == 0) begin
              m_sda = 1; m_scl = 1; m_drv = 1;
            end else m_sda = 0;
          end
          OP_WID, OP_WIDR, OP_WREG, OP_WDAT: begin
            if (sub == 0) begin
              if (op == OP_WID) m_shift = cfg_dev;
              else if (op == OP_WIDR) m_shift = cfg_dev | ReadBit;
              else if (op == OP_WREG) m_shift = m_reg;
              else m_shift = m_data;
            end
            if (sub < 16) begin
              if (!m_half) begin
                m_scl = 0;
                m_sda = m_shift[7 - m_bit[2:0]];
              end else m_scl = 1;
            end else if (sub == 16) begin
              m_scl = 0; m_drv = 0;
            end else m_scl = 1;
          end
          OP_STOP: begin
            if (sub == 0) m_sda = 0;
            else if (sub == 1) m_scl = 1;
            else m_sda = 1;
          end
          OP_READ: begin
            m_drv = 0;
            m_scl = m_half;
          end
          OP_NACK: begin
            if (sub == 1) begin
              m_sda = 1; m_scl = 1;
            end else if (sub == 2) m_scl = 0;
            else if (sub == 3) m_sda = 0;
          end
          default: ;
        endcase
      end
      if (is_byte(op) && sub == 17 && last && !m_read && it.sda_in) m_err = 1;
      if (op == OP_READ && m_half && first) m_rx = {m_rx[6:0], it.sda_in};
      m_cnt = (m_cnt + 1) & 32'hFFFF;
      if (last) begin
        m_cnt = 0;
        sub++;
        m_bit = sub[4:1];
        m_half = sub[0];
        if (sub >= op_len(op)) begin
          if (is_byte(op) || op == OP_READ) begin
            m_scl = 0; m_drv = 1;
          end else if (op == OP_START) m_scl = 0;
          m_step = m_step + 5'd1;
          m_bit = 0;
          m_half = 0;
          if (op == OP_END || step_op() == OP_END) begin
            m_busy = 0;
            done = 1;
            m_step = 0;
          end
        end
      end
    end
    o.scl_level = m_scl;
    o.sda_level = m_drv & m_sda;
    o.sda_drive = m_drv;
    o.busy_res = busy_o;
    o.done_res = done;
    o.read_value = m_rx;
    o.ack_error = m_err;
    return o;
  endfunction

  // hold until accepted, then queue the expected line state
  task automatic send_tick(input sccb_in_t it, input bit typed = 0,
                           input sccb_out_t typed_exp = '0);
    sccb_out_t o;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    o = bus_tick(it);
    line_q.push_back(typed ? typed_exp : o);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (line_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 1'b0} << 1; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegDevAddr) cfg_dev = val[7:0];
    else cfg_phase = val[15:0];
  endtask

  function automatic sccb_in_t rand_tick();
    sccb_in_t it;
    it.reg_addr = 8'($urandom);
    it.write_data = 8'($urandom);
    it.sda_in = ack_low ? ($urandom_range(0, 15) == 0) : 1'($urandom_range(0, 1));
    if (!m_busy) begin
      if ($urandom_range(0, 9) < 8) begin
        it.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        ack_low = $urandom_range(0, 2) != 0;
      end else it.command = $urandom_range(0, 1) ? CMD_NONE : CMD_RSVD;
    end else begin
      it.command = ($urandom_range(0, 19) == 0) ? cmd_e'($urandom_range(0, 3)) : CMD_NONE;
    end
    return it;
  endfunction

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    cmd_e        cmd;
    logic [7:0]  ra, wd;
    logic        sda;
    int unsigned fill;
    bit          typed;
    sccb_out_t   exp;
  } row_t;

  localparam sccb_out_t Idle  = '{1, 1, 1, 0, 0, 8'h00, 0};
  localparam sccb_out_t Start = '{1, 1, 1, 1, 0, 8'h00, 0};

  row_t rows[18] = '{
    '{0, 0, 0, CMD_NONE,  8'h00, 8'h00, 0, 0,   1, Idle},
    '{0, 0, 0, CMD_RSVD,  8'hFF, 8'hFF, 1, 0,   1, Idle},
    '{0, 0, 0, CMD_WRITE, 8'h00, 8'h00, 0, 10,  1, Start},
    '{1, RegPhaseTicks, 0, CMD_NONE, 0, 0, 0, 0, 0, '0},
    '{0, 0, 0, CMD_NONE,  8'h00, 8'h00, 0, 80,  0, '0},
    '{1, RegDevAddr, 255, CMD_NONE, 0, 0, 0, 0, 0, '0},
    '{0, 0, 0, CMD_WRITE, 8'hFF, 8'hFF, 1, 70,  0, '0},
    '{0, 0, 0, CMD_READ,  8'hAA, 8'h00, 1, 130, 0, '0},
    '{0, 0, 0, CMD_WRITE, 8'h55, 8'hAA, 0, 70,  0, '0},
    '{0, 0, 0, CMD_READ,  8'h00, 8'h00, 0, 10,  0, '0},
    '{0, 0, 0, CMD_WRITE, 8'h12, 8'h34, 0, 120, 0, '0},
    '{1, RegDevAddr, 0, CMD_NONE, 0, 0, 0, 0, 0, '0},
    '{1, RegPhaseTicks, 65535, CMD_NONE, 0, 0, 0, 0, 0, '0},
    '{0, 0, 0, CMD_WRITE, 8'h12, 8'h34, 0, 100, 0, '0},
    '{1, RegPhaseTicks, 2, CMD_NONE, 0, 0, 0, 0, 0, '0},
    '{0, 0, 0, CMD_NONE,  8'h00, 8'h00, 0, 200, 0, '0},
    '{1, RegPhaseTicks, 1, CMD_NONE, 0, 0, 0, 0, 0, '0},
    '{1, RegDevAddr, 66, CMD_NONE, 0, 0, 0, 0, 0, '0}
  };

  int unsigned seg_phase[4] = '{1, 3, 2, 1};

  initial begin
    sccb_in_t it;
    cfg_dev = DevAddrReset; cfg_phase = PhaseTicksReset;
    m_step = 0; m_cnt = 0; m_bit = 0; m_half = 0; m_shift = 0; m_rx = 0;
    m_reg = 0; m_data = 0; m_err = 0; m_read = 0; m_busy = 0;
    m_scl = 1; m_sda = 1; m_drv = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        reg_write(rows[r].idx, rows[r].val);
      end else begin
        it = '{rows[r].cmd, rows[r].ra, rows[r].wd, rows[r].sda};
        send_tick(it, rows[r].typed, rows[r].exp);
        repeat (rows[r].fill) send_tick('{CMD_NONE, 8'h00, 8'h00, rows[r].sda});
      end
    end
    for (int s = 0; s < 4; s++) begin
      reg_write(RegPhaseTicks, seg_phase[s]);
      reg_write(RegDevAddr, $urandom_range(0, 255));
      quiet = (s == 3);
      for (int n = 0; n < SegTicks; n++) begin
        if (s == 1 && n == 100) hold_req = 1;
        if (s == 2 && n == 100) drain();
        send_tick(rand_tick());
      end
    end
    push <= 1'b0;
    wait (line_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) stall_left--;
      else if (hold_req) begin
        stall_left = 300;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
      pop <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (line_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", out_o);
      end else begin
        sccb_out_t e;
        e = line_q.pop_front();
        if (out_o.scl_level !== e.scl_level || out_o.sda_level !== e.sda_level ||
            out_o.sda_drive !== e.sda_drive || out_o.busy_res !== e.busy_res ||
            out_o.done_res !== e.done_res || out_o.read_value !== e.read_value ||
            out_o.ack_error !== e.ack_error) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
